### hw/rtl/plk_pkg.sv
// Package for the positional list engine.
// Holds the action, status, cell and state codes used by the cell row and the top level.
// No dependencies.
`default_nettype none

package plk_pkg;

  localparam int DUMP_LIMIT = 32;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DELETE    = 3'd3,
    ACT_SEARCH    = 3'd4,
    ACT_DUMP      = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_RANGE     = 3'd2,
    STS_FULL      = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_e;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_ROTATE = 1'b1
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/plk_cell.sv
// One slot of the list: holds an entry and takes its neighbor's value on shift commands.
// Depends on plk_pkg for the cell command codes.
`default_nettype none

module plk_cell import plk_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX       = 0,
  parameter int CW          = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk_i,
  input  wire cell_op_e               op_i,
  input  wire logic [CW-1:0]          idx_i,
  input  wire logic [CW-1:0]          tail_i,
  input  wire logic [VALUE_WIDTH-1:0] new_val_i,
  input  wire logic [VALUE_WIDTH-1:0] prev_val_i,
  input  wire logic [VALUE_WIDTH-1:0] next_val_i,
  input  wire logic [VALUE_WIDTH-1:0] head_val_i,
  output logic      [VALUE_WIDTH-1:0] val_o
);

  localparam logic [CW-1:0] MyIdx = CW'(INDEX);

  logic [VALUE_WIDTH-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    case (op_i)
      CELL_INSERT: begin
        if (MyIdx == idx_i) begin
          val_d = new_val_i;
        end else if (MyIdx > idx_i) begin
          val_d = prev_val_i;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= idx_i) begin
          val_d = next_val_i;
        end
      end
      CELL_ROTATE: begin
        // wrap the head word around to the tail slot
        if (MyIdx == tail_i) begin
          val_d = head_val_i;
        end else begin
          val_d = next_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

### hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: a row of plk_cell slots plus the control logic.
// Depends on plk_pkg and plk_cell.
//
//  channel | handshake              | fields
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid_i / in_stall_o | action_i, item_value_i, position_i
//  out     | out_valid_o / out_stall_i | status_o, found_position_o, entry_value_o, last_o
//
// Inserts, deletes and every item that fails a check give one word.
// Search and dump rotate the cell row once around, one slot per cycle while the output is not
// stalled, and stall the input until the rotation ends; dump streams one word per cycle, up
// to DUMP_LIMIT words, while the output is not stalled.
// Reset clears the entry count, the sequencer and the output valid; entries need no reset.
// A stalled output holds the rotation and keeps new input words out.
`default_nettype none

module positional_list_engine import plk_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         action_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic [5:0]         position_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic [5:0]              found_position_o,
  output logic signed [31:0]      entry_value_o,
  output logic                    last_o
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > 6) ? CW : 6;

  // cell row
  logic [VALUE_WIDTH-1:0] vals [CAPACITY];
  logic [VALUE_WIDTH-1:0] head;
  logic [VALUE_WIDTH-1:0] new_val;
  cell_op_e               cell_op;
  logic [CW-1:0]          cell_idx;
  logic [CW-1:0]          tail;

  // control
  state_e                 state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          step_q, step_d;
  logic                   found_q, found_d;
  logic                   dump_q, dump_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;

  // output register
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic [5:0]  fpos_q, fpos_d;
  logic [31:0] entry_q, entry_d;
  logic        last_q, last_d;

  logic              emit_ok, emit, accept, full;
  logic [CMP_W-1:0]  pos_c, cnt_c;
  logic [CW-1:0]     dump_last;

  assign new_val = VALUE_WIDTH'({{64{item_value_i[31]}}, item_value_i});
  assign head    = vals[0];
  assign tail    = cnt_q - CW'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_val, next_val;
    if (i == 0) begin : g_first
      assign prev_val = new_val;
    end else begin : g_mid
      assign prev_val = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_val = vals[i];
    end else begin : g_inner
      assign next_val = vals[i+1];
    end
    plk_cell #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX       (i),
      .CW          (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (cell_op),
      .idx_i      (cell_idx),
      .tail_i     (tail),
      .new_val_i  (new_val),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .head_val_i (head),
      .val_o      (vals[i])
    );
  end

  assign emit_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !emit_ok;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CW'(CAPACITY));
  assign pos_c      = CMP_W'(position_i);
  assign cnt_c      = CMP_W'(cnt_q);
  assign dump_last  = (cnt_q > DUMP_LIMIT) ? CW'(DUMP_LIMIT - 1) : tail;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    found_d  = found_q;
    dump_d   = dump_q;
    key_d    = key_q;
    cell_op  = CELL_HOLD;
    cell_idx = '0;
    emit     = 1'b0;
    status_d = STS_OK;
    fpos_d   = '0;
    entry_d  = '0;
    last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_INS_FRONT, ACT_INS_BACK: begin
              emit = 1'b1;
              if (full) begin
                status_d = STS_FULL;
              end else begin
                cell_op  = CELL_INSERT;
                cell_idx = (action_e'(action_i) == ACT_INS_FRONT) ? '0 : cnt_q;
                cnt_d    = cnt_q + CW'(1);
              end
            end
            ACT_INS_POS: begin
              emit = 1'b1;
              if (full) begin
                status_d = STS_FULL;
              end else if (pos_c == CMP_W'(1) || (pos_c > CMP_W'(1) && pos_c <= cnt_c)) begin
                cell_op  = CELL_INSERT;
                cell_idx = CW'(pos_c - CMP_W'(1));
                cnt_d    = cnt_q + CW'(1);
              end else begin
                status_d = STS_RANGE;
              end
            end
            ACT_DELETE: begin
              emit = 1'b1;
              if (cnt_q == '0) begin
                status_d = STS_EMPTY;
              end else if (pos_c >= CMP_W'(1) && pos_c <= cnt_c) begin
                cell_op  = CELL_DELETE;
                cell_idx = CW'(pos_c - CMP_W'(1));
                cnt_d    = cnt_q - CW'(1);
              end else begin
                status_d = STS_RANGE;
              end
            end
            ACT_SEARCH, ACT_DUMP: begin
              if (cnt_q == '0) begin
                emit     = 1'b1;
                status_d = STS_EMPTY;
              end else begin
                state_d = ST_ROTATE;
                step_d  = '0;
                found_d = 1'b0;
                dump_d  = (action_e'(action_i) == ACT_DUMP);
                key_d   = new_val;
              end
            end
            default: begin
              emit     = 1'b1;
              status_d = STS_RANGE;
            end
          endcase
        end
      end
      ST_ROTATE: begin
        // advance one slot only when the output register can take a word
        if (emit_ok) begin
          cell_op = CELL_ROTATE;
          step_d  = step_q + CW'(1);
          if (dump_q) begin
            if (step_q < DUMP_LIMIT) begin
              emit    = 1'b1;
              entry_d = 32'({{64{head[VALUE_WIDTH-1]}}, head});
              last_d  = (step_q == dump_last);
            end
          end else if (!found_q && head == key_q) begin
            emit    = 1'b1;
            found_d = 1'b1;
            fpos_d  = 6'(CMP_W'(step_q) + CMP_W'(1));
          end else if (!found_q && step_q == tail) begin
            emit     = 1'b1;
            status_d = STS_NOT_FOUND;
          end
          if (step_q == tail) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    found_q <= found_d;
    dump_q  <= dump_d;
    key_q   <= key_d;
    if (emit) begin
      status_q <= status_d;
      fpos_q   <= fpos_d;
      entry_q  <= entry_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = fpos_q;
  assign entry_value_o    = entry_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for positional_list_engine: drives list operations through
// the valid/stall input channel and checks every output word against a mirror list.
// Depends on plk_pkg and the positional_list_engine RTL.
module tb;
  import plk_pkg::*;

  localparam int LIST_CAPACITY = 32;
  localparam int HOLD_CYCLES   = 150;
  localparam int TAIL_CYCLES   = 40;
  localparam int IDLE_LIMIT    = 2000;

  // Undefined action codes; the block answers both with an out-of-range status
  localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  typedef struct {
    status_e            status;
    logic [5:0]         found_pos;
    logic signed [31:0] value;
    logic               last;
  } list_reply_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [2:0]         action_i     = ACT_SEARCH;
  logic signed [31:0] item_value_i = '0;
  logic [5:0]         position_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [2:0]         status_o;
  logic [5:0]         found_position_o;
  logic signed [31:0] entry_value_o;
  logic               last_o;

  list_reply_t        replies_due[$];
  logic signed [31:0] list_entries[$];

  int errors      = 0;
  int gap_max     = 0;
  int burst_left  = 1;
  int stall_pct   = 0;
  bit hold_armed  = 1'b0;
  int hold_left   = 0;
  int idle_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  positional_list_engine #(
    .CAPACITY    (LIST_CAPACITY),
    .VALUE_WIDTH (32)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .item_value_i     (item_value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .entry_value_o    (entry_value_o),
    .last_o           (last_o)
  );

  function automatic void push_reply(status_e st, logic [5:0] fpos,
                                     logic signed [31:0] val, logic lst);
    list_reply_t r;
    r.status    = st;
    r.found_pos = fpos;
    r.value     = val;
    r.last      = lst;
    replies_due.push_back(r);
  endfunction

  // Apply one accepted word to the mirror list and queue the words it should produce
  function automatic void apply_action(logic [2:0] act, logic signed [31:0] value,
                                       logic [5:0] pos);
    int count;
    int p;
    int hit;
    int n;
    count = list_entries.size();
    p     = int'(pos);
    hit   = 0;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (count >= LIST_CAPACITY) begin
          push_reply(STS_FULL, '0, '0, 1'b1);
        end else begin
          if (act == ACT_INS_FRONT) list_entries.push_front(value);
          else list_entries.push_back(value);
          push_reply(STS_OK, '0, '0, 1'b1);
        end
      end
      ACT_INS_POS: begin
        if (count >= LIST_CAPACITY) begin
          push_reply(STS_FULL, '0, '0, 1'b1);
        end else if (p == 1 || (p > 1 && p <= count)) begin
          list_entries.insert(p - 1, value);
          push_reply(STS_OK, '0, '0, 1'b1);
        end else begin
          push_reply(STS_RANGE, '0, '0, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (count == 0) begin
          push_reply(STS_EMPTY, '0, '0, 1'b1);
        end else if (p >= 1 && p <= count) begin
          list_entries.delete(p - 1);
          push_reply(STS_OK, '0, '0, 1'b1);
        end else begin
          push_reply(STS_RANGE, '0, '0, 1'b1);
        end
      end
      ACT_SEARCH: begin
        if (count == 0) begin
          push_reply(STS_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < count; i++) begin
            if (list_entries[i] == value) begin
              hit = i + 1;
              break;
            end
          end
          if (hit != 0) push_reply(STS_OK, hit[5:0], '0, 1'b1);
          else push_reply(STS_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      ACT_DUMP: begin
        if (count == 0) begin
          push_reply(STS_EMPTY, '0, '0, 1'b1);
        end else begin
          n = (count < DUMP_LIMIT) ? count : DUMP_LIMIT;
          for (int i = 0; i < n; i++) push_reply(STS_OK, '0, list_entries[i], i == n - 1);
        end
      end
      default: push_reply(STS_RANGE, '0, '0, 1'b1);
    endcase
  endfunction

  // Offer one word and hold it until accepted; end a burst with a random gap when gap_max is set
  task automatic send_word(input logic [2:0] act, input logic signed [31:0] value,
                           input logic [5:0] pos);
    int gap;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    item_value_i <= value;
    position_i   <= pos;
    do @(posedge clk_i); while (in_stall_o);
    apply_action(act, value, pos);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(12, 1);
      if (gap_max > 0) begin
        gap = $urandom_range(gap_max, 1);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7, 0))
      0: return int'($urandom_range(6, 0)) - 3;
      1: begin
        case ($urandom_range(3, 0))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      2, 3: begin
        if (list_entries.size() != 0)
          return list_entries[$urandom_range(list_entries.size() - 1, 0)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_position(int count);
    case ($urandom_range(9, 0))
      0: return '0;
      1: return (count < LIST_CAPACITY) ? 6'(count + 1) : 6'(LIST_CAPACITY);
      2: return 6'($urandom_range(LIST_CAPACITY, 0));
      default: return 6'($urandom_range((count > 1) ? count : 1, 1));
    endcase
  endfunction

  function automatic logic [2:0] pick_insert();
    case ($urandom_range(2, 0))
      0: return ACT_INS_FRONT;
      1: return ACT_INS_BACK;
      default: return ACT_INS_POS;
    endcase
  endfunction

  // Receiver: a long hold when armed, otherwise random stalls at the current rate
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_replies
    list_reply_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $error("word with no reply due: status %0d entry_value %0d", status_o, entry_value_o);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (found_position_o !== want.found_pos) begin
            $error("found_position: expected %0d, got %0d", want.found_pos, found_position_o);
            errors++;
          end
          if (entry_value_o !== want.value) begin
            $error("entry_value: expected %0d, got %0d", want.value, entry_value_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    gap_max   = 4;
    stall_pct = 25;
    send_word(ACT_DUMP, 0, 0);
    send_word(ACT_SEARCH, 7, 0);
    send_word(ACT_DELETE, 0, 1);
    send_word(ACT_INS_POS, 1, 0);
    send_word(ACT_INS_POS, 1, 2);
    // position 1 is accepted even on an empty list
    send_word(ACT_INS_POS, 32'h7fff_ffff, 1);
    send_word(ACT_INS_FRONT, 32'h8000_0000, 0);
    send_word(ACT_INS_BACK, 0, 0);
    send_word(ACT_INS_BACK, -1, 0);
    send_word(ACT_INS_POS, 5, 3);
    send_word(ACT_INS_POS, 32'h5555_5555, 5);
    send_word(ACT_INS_POS, 32'haaaa_aaaa, 7);
    send_word(ACT_INS_POS, 9, 32);
    send_word(ACT_INS_POS, 9, 6'h3f);
    send_word(ACT_SEARCH, 32'h8000_0000, 0);
    send_word(ACT_SEARCH, -1, 0);
    send_word(ACT_SEARCH, 12345, 0);
    // duplicate value: search must report the first match
    send_word(ACT_INS_FRONT, 5, 0);
    send_word(ACT_SEARCH, 5, 0);
    send_word(ACT_UNDEF_LO, 1, 1);
    send_word(ACT_UNDEF_HI, -1, 6'h3f);
    send_word(ACT_DELETE, 0, 0);
    send_word(ACT_DELETE, 0, 8);
    send_word(ACT_DELETE, 0, 7);
    send_word(ACT_DELETE, 0, 1);
    send_word(ACT_DUMP, 0, 0);
  endtask

  task automatic test_full_list();
    int count;
    gap_max   = 0;
    stall_pct = 0;
    while (list_entries.size() < LIST_CAPACITY) begin
      count = list_entries.size();
      send_word(pick_insert(), $urandom, 6'($urandom_range((count > 1) ? count : 1, 1)));
    end
    send_word(ACT_INS_FRONT, 1, 0);
    send_word(ACT_INS_BACK, 1, 0);
    send_word(ACT_INS_POS, 1, 1);
    // longest dump, streamed back to back
    send_word(ACT_DUMP, 0, 0);
    send_word(ACT_SEARCH, list_entries[LIST_CAPACITY - 1], 0);
    send_word(ACT_DELETE, 0, 6'(LIST_CAPACITY));
    send_word(ACT_DELETE, 0, 6'(LIST_CAPACITY));
    send_word(ACT_DELETE, 0, 1);
  endtask

  task automatic test_receiver_hold();
    gap_max    = 0;
    stall_pct  = 0;
    hold_armed = 1'b1;
    for (int n = 0; n < 12; n++) begin
      if (n % 3 == 2) send_word(ACT_SEARCH, pick_value(), 0);
      else send_word(pick_insert(), pick_value(), pick_position(list_entries.size()));
    end
  endtask

  task automatic test_random_mix(input int items, input int grow_pct);
    int         roll;
    logic [2:0] act;
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(99, 0);
      if (roll < 2) act = $urandom_range(1, 0) ? ACT_UNDEF_LO : ACT_UNDEF_HI;
      else if (roll < 7) act = ACT_DUMP;
      else if (roll < 27) act = ACT_SEARCH;
      else if ($urandom_range(99, 0) < grow_pct) act = pick_insert();
      else act = ACT_DELETE;
      send_word(act, pick_value(), pick_position(list_entries.size()));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_list();
    test_receiver_hold();
    gap_max   = 6;
    stall_pct = 30;
    test_random_mix(100, 80);
    gap_max   = 3;
    stall_pct = 10;
    test_random_mix(90, 25);
    gap_max   = 8;
    stall_pct = 60;
    test_random_mix(100, 55);
    gap_max   = 0;
    stall_pct = 0;
    test_random_mix(40, 55);
    drain_replies();
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
